[rtl/psh_pkg.sv]
// Shared types, widths and constants of the program-counter sampling histogram.
`default_nettype none

package psh_pkg;

    localparam int ADDR_W      = 64;
    localparam int TOTAL_W     = 64;
    localparam int HITS_W      = 32;
    localparam int INDEX_W     = 13;
    localparam int PCT_W       = 7;
    localparam int PCT_SCALE_W = 7;
    localparam int NUM_W       = HITS_W + PCT_SCALE_W;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = HITS_W + ADDR_W + TOTAL_W + PCT_W + 1;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;
    localparam int REG_SEL_BIT = 3;

    localparam int DEF_BUCKET_COUNT = 8192;
    localparam int DEF_BUCKET_SHIFT = 12;

    localparam logic [ADDR_W-1:0] RESET_BASE    = 64'hFFFF_8000_0000_0000;
    localparam logic [PCT_W-1:0]  PCT_SCALE     = 7'd100;
    localparam logic [HITS_W-1:0] SHOW_MIN_HITS = 32'd50;

    // Request kinds carried on the input tuser line.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Register select, taken from one address bit.
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_BASE   = 1'b1;

    typedef struct packed {
        logic              enable;
        logic [ADDR_W-1:0] region_base;
    } psh_cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_S_CHECK,
        ST_S_WRITE,
        ST_R_READ,
        ST_R_MUL,
        ST_R_START,
        ST_R_DIV,
        ST_R_DONE
    } psh_state_t;

endpackage

`default_nettype wire

[rtl/pc_sample_histogram.sv]
// Top level of the program-counter sampling histogram with its request sequencer.
`default_nettype none

// Program-counter sampling histogram. Sample requests (tuser 0) whose address lies in
// [region_base, region_base + BUCKET_COUNT << BUCKET_SHIFT) bump their bucket counter and a
// 64-bit total while enable is set; they return nothing. Read requests (tuser 1) return the
// bucket's count, start address, the total, the load percentage and a shown flag. One
// request is handled at a time: a sample checks its range and reads its counter, then
// writes the counter back; a read waits on the divider, which forms one quotient bit of
// count*100/total per cycle. A finished read result waits in the output register while the
// next request is already taken. After reset the counter memory is swept to zero, one entry
// per cycle, before the first request is accepted; configuration writes are taken during
// that sweep.
module pc_sample_histogram
    import psh_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int BUCKET_SHIFT = DEF_BUCKET_SHIFT
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // sample_address [63:0], bucket_index [76:64], zero fill [79:77]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // bucket_hits [31:0], bucket_start [95:32], total_hits [159:96],
    // load_percent [166:160], shown [167]
    output logic      [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(BUCKET_COUNT);
    localparam int RD_W  = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    psh_cfg_t          cfg;
    psh_state_t        state_reg;
    psh_state_t        state_next;

    logic [IDX_W-1:0]   clr_idx_reg;
    logic [ADDR_W-1:0]  off_reg;
    logic               below_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic               idx_ok_reg;
    logic [IDX_W-1:0]   bkt_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [HITS_W-1:0]  hits_reg;
    logic [NUM_W-1:0]   numer_reg;
    logic [ADDR_W-1:0]  start_reg;
    logic               m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [ADDR_W:0]    off_full;
    logic [RD_W-1:0]    idx_wide;
    logic [IDX_W-1:0]   bkt_c;
    logic               sample_hit;
    logic [HITS_W-1:0]  hits_c;
    logic [PCT_W-1:0]   pct_c;
    logic               shown_c;

    logic               accept;
    logic               out_free;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [HITS_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [HITS_W-1:0]  mem_rdata;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_q;
    logic               out_load;

    psh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psh_counter_ram #(
        .DEPTH (BUCKET_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    psh_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer_reg),
        .denom    (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The borrow of the offset subtraction marks an address below the region.
    assign off_full   = {1'b0, s_tdata[ADDR_W-1:0]} - {1'b0, cfg.region_base};
    assign idx_wide   = RD_W'(idx_reg);
    assign bkt_c      = off_reg[BUCKET_SHIFT +: IDX_W];
    assign sample_hit = cfg.enable && !below_reg
                        && ((off_reg >> BUCKET_SHIFT) < ADDR_W'(BUCKET_COUNT));
    assign hits_c     = idx_ok_reg ? mem_rdata : '0;

    always_comb
    begin
        if (total_reg == '0)
        begin
            pct_c = '0;
        end
        else if (div_q > NUM_W'(PCT_SCALE))
        begin
            pct_c = PCT_SCALE;
        end
        else
        begin
            pct_c = div_q[PCT_W-1:0];
        end
    end

    assign shown_c = (total_reg != '0) && ((pct_c != '0) || (hits_reg > SHOW_MIN_HITS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == IDX_W'(BUCKET_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser == OP_READ) ? ST_R_READ : ST_S_CHECK;
                end
            end
            ST_S_CHECK: state_next = sample_hit ? ST_S_WRITE : ST_IDLE;
            ST_S_WRITE: state_next = ST_IDLE;
            ST_R_READ:  state_next = ST_R_MUL;
            ST_R_MUL:   state_next = ST_R_START;
            ST_R_START: state_next = ST_R_DIV;
            ST_R_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_R_DONE;
                end
            end
            ST_R_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = '0;
        mem_raddr = idx_wide[IDX_W-1:0];
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_S_CHECK:
            begin
                mem_raddr = bkt_c;
            end
            ST_S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = bkt_reg;
                mem_wdata = mem_rdata + HITS_W'(1);
            end
            ST_R_START:
            begin
                div_start = 1'b1;
            end
            ST_R_DONE:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (state_reg == ST_S_WRITE)
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            off_reg    <= off_full[ADDR_W-1:0];
            below_reg  <= off_full[ADDR_W];
            idx_reg    <= s_tdata[ADDR_W +: INDEX_W];
            idx_ok_reg <= 32'(s_tdata[ADDR_W +: INDEX_W]) < 32'(BUCKET_COUNT);
        end
        if (state_reg == ST_S_CHECK)
        begin
            bkt_reg <= bkt_c;
        end
        if (state_reg == ST_R_READ)
        begin
            start_reg <= cfg.region_base + (ADDR_W'(idx_reg) << BUCKET_SHIFT);
        end
        if (state_reg == ST_R_MUL)
        begin
            hits_reg  <= hits_c;
            numer_reg <= NUM_W'(hits_c) * NUM_W'(PCT_SCALE);
        end
        if (out_load)
        begin
            m_data_reg <= {shown_c, pct_c, total_reg, start_reg, hits_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s_tready && mem_we && (mem_wdata == '0)))
        else $error("input taken or memory not written during the clearing sweep");

    a_total_only_on_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_S_WRITE) |=> $stable(total_reg))
        else $error("total changed outside a counted sample");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_R_DIV))
        else $error("divider finished while the sequencer was not waiting for it");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_R_DONE))
        else $error("result raised without a finished read request");
`endif

endmodule

`default_nettype wire

[rtl/psh_regs.sv]
// Configuration register file with its APB-style access port.
`default_nettype none

module psh_regs
    import psh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output psh_cfg_t                   cfg
);

    logic              enable_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            base_reg   <= RESET_BASE;
        end
        else if (wr_en)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_BASE:   base_reg   <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_SEL_BIT])
            REG_ENABLE: prdata = CFG_DATA_W'(enable_reg);
            REG_BASE:   prdata = base_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.enable      = enable_reg;
    assign cfg.region_base = base_reg;

endmodule

`default_nettype wire

[rtl/psh_counter_ram.sv]
// Single-write, single-read memory holding the per-bucket hit counters.
`default_nettype none

module psh_counter_ram
    import psh_pkg::*;
#(
    parameter int DEPTH = DEF_BUCKET_COUNT,
    parameter int AW    = $clog2(DEF_BUCKET_COUNT)
)(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [HITS_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [HITS_W-1:0] rd_data
);

    logic [HITS_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/psh_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module psh_divider
    import psh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NUM_W-1:0]   numer,
    input  wire logic [TOTAL_W-1:0] denom,
    output logic                    done,
    output logic      [NUM_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TOTAL_W-1:0]   rem_reg;
    logic [TOTAL_W-1:0]   den_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [TOTAL_W:0]     rem_shift;
    logic [TOTAL_W+1:0]   diff;
    logic                 fits;
    logic [TOTAL_W-1:0]   rem_next;

    // The numerator shifts out of the top of q_reg while quotient bits enter below.
    assign rem_shift = {rem_reg, q_reg[NUM_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign fits      = !diff[TOTAL_W+1];
    assign rem_next  = fits ? diff[TOTAL_W-1:0] : rem_shift[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= denom;
            q_reg   <= numer;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

[tb/sv/pc_sample_histogram_test.sv]
// Self-checking testbench for the program-counter sampling histogram.
`timescale 1ns / 100ps

module pc_sample_histogram_test
    import psh_pkg::*;
();

    localparam int BUCKETS           = DEF_BUCKET_COUNT;
    localparam int BUCKET_SHIFT_BITS = DEF_BUCKET_SHIFT;
    localparam int BUCKET_BYTES      = 1 << BUCKET_SHIFT_BITS;
    localparam int SPAN_BYTES        = BUCKETS * BUCKET_BYTES;
    localparam logic [ADDR_W-1:0] REGION_SPAN = ADDR_W'(SPAN_BYTES);
    localparam logic [ADDR_W-1:0] ALL_ONES    = {ADDR_W{1'b1}};
    localparam int HOT_COUNT      = 6;
    localparam int SETTLE_CYCLES  = 10;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int PHASE_REQUESTS = 215;

    typedef struct packed {
        logic [HITS_W-1:0]  hits;
        logic [ADDR_W-1:0]  start;
        logic [TOTAL_W-1:0] total;
        logic [PCT_W-1:0]   percent;
        logic               shown;
    } bucket_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = OP_SAMPLE;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    // Predicted histogram state and register copies.
    logic [HITS_W-1:0]  hist_count [BUCKETS];
    logic [TOTAL_W-1:0] hist_total;
    logic               cfg_enable;
    logic [ADDR_W-1:0]  cfg_base;

    bucket_report_t pending_reports [$];
    int hot_buckets [HOT_COUNT];
    bit no_idle = 1'b0;
    int mismatches = 0;
    int samples_sent = 0;
    int reads_checked = 0;
    int ready_stall = 0;

    pc_sample_histogram #(
        .BUCKET_COUNT(BUCKETS),
        .BUCKET_SHIFT(BUCKET_SHIFT_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_histogram();
        for (int i = 0; i < BUCKETS; i++)
            hist_count[i] = '0;
        hist_total = '0;
        cfg_enable = 1'b1;
        cfg_base = RESET_BASE;
    endfunction

    function automatic void record_sample(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] bucket;
        samples_sent++;
        offset = addr - cfg_base;
        bucket = offset >> BUCKET_SHIFT_BITS;
        if (cfg_enable && addr >= cfg_base && bucket < ADDR_W'(BUCKETS))
        begin
            hist_count[bucket[INDEX_W-1:0]] = hist_count[bucket[INDEX_W-1:0]] + HITS_W'(1);
            hist_total = hist_total + TOTAL_W'(1);
        end
    endfunction

    function automatic bucket_report_t report_bucket(input logic [INDEX_W-1:0] idx);
        bucket_report_t r;
        logic [63:0] scaled;
        logic [63:0] pct;
        r.hits = hist_count[idx];
        r.start = cfg_base + (ADDR_W'(idx) << BUCKET_SHIFT_BITS);
        r.total = hist_total;
        r.shown = 1'b0;
        pct = '0;
        if (hist_total != '0)
        begin
            // The product never exceeds 39 bits, so 64-bit arithmetic is exact.
            scaled = 64'(r.hits) * 64'd100;
            pct = scaled / hist_total;
            if (pct > 64'd100)
                pct = 64'd100;
            r.shown = (pct >= 64'd1) || (r.hits > 32'd50);
        end
        r.percent = pct[PCT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_sample_address();
        int r;
        logic [ADDR_W-1:0] hot;
        r = $urandom_range(0, 99);
        hot = ADDR_W'(hot_buckets[$urandom_range(0, HOT_COUNT - 1)]) << BUCKET_SHIFT_BITS;
        if (r < 55)
            return cfg_base + hot + ADDR_W'($urandom_range(0, BUCKET_BYTES - 1));
        if (r < 80)
            return cfg_base + ADDR_W'($urandom_range(0, SPAN_BYTES - 1));
        // Just below the watched region, or straddling its upper end.
        if (r < 90)
        begin
            if ($urandom_range(0, 1) == 0)
                return cfg_base - ADDR_W'($urandom_range(1, 8));
            return cfg_base + REGION_SPAN - 64'd4 + ADDR_W'($urandom_range(0, 7));
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [INDEX_W-1:0] pick_read_index();
        if ($urandom_range(0, 99) < 60)
            return INDEX_W'(hot_buckets[$urandom_range(0, HOT_COUNT - 1)]);
        return INDEX_W'($urandom_range(0, BUCKETS - 1));
    endfunction

    task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic [INDEX_W-1:0] idx);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(IN_DATA_W - INDEX_W - ADDR_W){1'b0}}, idx, addr};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_READ)
            pending_reports.push_back(report_bucket(idx));
        else
            record_sample(addr);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Holds the request side quiet until every read has answered and a sample
    // still in flight has had time to write back.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic sel, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(sel) << REG_SEL_BIT;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == REG_ENABLE)
            cfg_enable = value[0];
        else
            cfg_base = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_reset_state();
        set_register(REG_ENABLE, 64'd1);
        set_register(REG_BASE, RESET_BASE);
        send_request(OP_READ, ALL_ONES, '0);
        send_request(OP_READ, '0, INDEX_W'(BUCKETS - 1));
    endtask

    task automatic test_sample_edges();
        send_request(OP_SAMPLE, cfg_base, '1);
        send_request(OP_SAMPLE, cfg_base + ADDR_W'(BUCKET_BYTES - 1), '0);
        send_request(OP_SAMPLE, cfg_base + ADDR_W'(BUCKET_BYTES), '0);
        send_request(OP_SAMPLE, cfg_base + REGION_SPAN - ADDR_W'(1), '0);
        // The following three fall outside the region and are dropped.
        send_request(OP_SAMPLE, cfg_base + REGION_SPAN, '0);
        send_request(OP_SAMPLE, cfg_base - ADDR_W'(1), '0);
        send_request(OP_SAMPLE, '0, '0);
        send_request(OP_READ, '0, '0);
        send_request(OP_READ, '0, INDEX_W'(1));
        send_request(OP_READ, '0, INDEX_W'(BUCKETS - 1));
    endtask

    task automatic test_paused();
        set_register(REG_ENABLE, 64'd0);
        send_request(OP_SAMPLE, cfg_base + ADDR_W'(2 * BUCKET_BYTES), '0);
        send_request(OP_READ, '0, INDEX_W'(2));
        set_register(REG_ENABLE, 64'd1);
    endtask

    task automatic test_unaligned_base();
        set_register(REG_BASE, RESET_BASE + 64'h123);
        send_request(OP_SAMPLE, cfg_base, '0);
        send_request(OP_SAMPLE, cfg_base + ADDR_W'(3 * BUCKET_BYTES - 1), '0);
        send_request(OP_READ, '0, INDEX_W'(2));
    endtask

    task automatic test_region_wrap();
        // The region would run past the top of the address space.
        set_register(REG_BASE, 64'hFFFF_FFFF_FFF0_0000);
        send_request(OP_SAMPLE, ALL_ONES, '0);
        send_request(OP_SAMPLE, '0, '0);
        send_request(OP_READ, '0, INDEX_W'(255));
        send_request(OP_READ, '0, INDEX_W'(BUCKETS - 1));
        set_register(REG_BASE, ALL_ONES);
        send_request(OP_SAMPLE, ALL_ONES, '0);
        send_request(OP_READ, '0, '0);
        set_register(REG_BASE, '0);
        send_request(OP_SAMPLE, '0, '0);
        send_request(OP_READ, ALL_ONES, '0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_register(REG_BASE, RESET_BASE);
                1: set_register(REG_BASE, {$urandom, $urandom} & ~64'(BUCKET_BYTES - 1));
                2: set_register(REG_ENABLE, 64'd0);
                default: set_register(REG_BASE,
                                      64'hFFFF_FFFF_FF00_0000 | 64'($urandom_range(1, 4095)));
            endcase
            for (int h = 0; h < HOT_COUNT; h++)
                hot_buckets[h] = $urandom_range(0, BUCKETS - 1);
            no_idle = (phase == 1);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (phase == 2 && n == 60)
                    set_register(REG_ENABLE, 64'd1);
                if ($urandom_range(0, 99) < 70)
                    send_request(OP_SAMPLE, pick_sample_address(),
                                 INDEX_W'($urandom_range(0, BUCKETS - 1)));
                else
                    send_request(OP_READ, {$urandom, $urandom}, pick_read_index());
            end
        end
        no_idle = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (ready_stall > 0)
        begin
            m_tready <= 1'b0;
            ready_stall = ready_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 2) == 0)
                ready_stall = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        bucket_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("read result with no read request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                reads_checked++;
                check_field("bucket_hits", 64'(want.hits), 64'(m_tdata[31:0]));
                check_field("bucket_start", want.start, m_tdata[95:32]);
                check_field("total_hits", want.total, m_tdata[159:96]);
                check_field("load_percent", 64'(want.percent), 64'(m_tdata[166:160]));
                check_field("shown", 64'(want.shown), 64'(m_tdata[167]));
            end
        end
    end

    initial
    begin
        clear_histogram();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_sample_edges();
        test_paused();
        test_unaligned_base();
        test_region_wrap();
        test_random_traffic();
        @(negedge clk);
        s_tvalid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending_reports.size() != 0; w++)
            @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $error("%0d bucket reads never answered", pending_reports.size());
            mismatches++;
        end
        repeat (60) @(posedge clk);
        $display("Sent %0d samples (%0d counted) and checked %0d bucket reads.",
                 samples_sent, hist_total, reads_checked);
        $display("Covered paused and running profiling, aligned, unaligned and wrapping bases.");
        if (mismatches == 0)
            $display("pc_sample_histogram verification clean");
        else
            $display("pc_sample_histogram verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("pc_sample_histogram verification failed");
        $finish;
    end

endmodule
